/* hw/rtl/rv64se_pkg.sv */
// Shared constants and types for the RV64 subset execute block.
package rv64se_pkg;

    // Major opcodes
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;

    // funct7 / funct6 codes
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_MUL  = 7'b0000001;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [5:0] F6_BASE = 6'b000000;
    localparam logic [5:0] F6_ALT  = 6'b010000;

    // funct3 codes
    localparam logic [2:0] F3_ADD = 3'b000;
    localparam logic [2:0] F3_SLL = 3'b001;
    localparam logic [2:0] F3_SR  = 3'b101;
    localparam logic [2:0] F3_AND = 3'b111;
    localparam logic [2:0] F3_BEQ = 3'b000;
    localparam logic [2:0] F3_BNE = 3'b001;
    localparam logic [2:0] F3_BLT = 3'b100;
    localparam logic [2:0] F3_BGE = 3'b101;

    // Combined {funct7, funct3} codes of the register-register group
    localparam logic [9:0] FN_ADD = {F7_BASE, F3_ADD};
    localparam logic [9:0] FN_MUL = {F7_MUL, F3_ADD};
    localparam logic [9:0] FN_SUB = {F7_ALT, F3_ADD};
    localparam logic [9:0] FN_SLL = {F7_BASE, F3_SLL};
    localparam logic [9:0] FN_SRL = {F7_BASE, F3_SR};
    localparam logic [9:0] FN_SRA = {F7_ALT, F3_SR};
    localparam logic [9:0] FN_AND = {F7_BASE, F3_AND};

    // Result status
    typedef logic [1:0] t_status;
    localparam t_status ST_RUN   = 2'd0;
    localparam t_status ST_HALT  = 2'd1;
    localparam t_status ST_BADOP = 2'd2;
    localparam t_status ST_BADFN = 2'd3;

    // Input kinds
    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_EXEC    = 1'b1;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_START_PC  = 3'd0;
    localparam t_cfg_idx CFG_STACK_TOP = 3'd1;
    localparam t_cfg_idx CFG_ARG_ZERO  = 3'd2;
    localparam t_cfg_idx CFG_ARG_ONE   = 3'd3;
    localparam t_cfg_idx CFG_ARG_TWO   = 3'd4;
    localparam t_cfg_idx CFG_ARG_THREE = 3'd5;

    // Architectural register numbers loaded on restart
    localparam logic [4:0] REG_SP = 5'd2;
    localparam logic [4:0] REG_A0 = 5'd10;
    localparam logic [4:0] REG_A1 = 5'd11;
    localparam logic [4:0] REG_A2 = 5'd12;
    localparam logic [4:0] REG_A3 = 5'd13;

endpackage

/* hw/rtl/rv64se_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rv64se_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/rv64_subset_execute.sv */
// Top level: RV64 subset execute stage with register file, pc and result register.
//
//  channel   dir  handshake                 payload
//  s (item)  in   i_s_tvalid / o_s_tready   i_s_tdata = instr_word, i_s_tuser = kind
//  m (result)out  o_m_tvalid / i_m_tready   o_m_tdata = next_pc, status, a0_value
//  cfg       in   i_cfg_wr_en               i_cfg_index, i_cfg_wdata
//
// One item per cycle while results are taken and no MUL is in execute: an accepted
// transaction is held in the execute register while the register file copies return its
// operands, then decode, ALU and writeback run into the result register. MUL is held in
// execute for partial products, then sum. Reset is synchronous, active low; register file
// contents come from per-entry valid bits, so no clearing pass is needed. A stalled
// result holds the execute register; the input keeps accepting while it is empty.
module rv64_subset_execute #(
    parameter int NUM_REGS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // item input
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,    // [31:0] instr_word
    input  logic         i_s_tuser,    // [0] kind
    // result output
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata,    // [63:0] next_pc, [65:64] status, [129:66] a0_value
    // configuration writes
    input  logic         i_cfg_wr_en,
    input  rv64se_pkg::t_cfg_idx i_cfg_index,
    input  logic [63:0]  i_cfg_wdata
);

    import rv64se_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    // configuration and restart snapshot
    logic [63:0] r_cfg_pc, r_cfg_sp, r_cfg_a0, r_cfg_a1, r_cfg_a2, r_cfg_a3;
    logic [63:0] r_init_sp, r_init_a0, r_init_a1, r_init_a2, r_init_a3;

    // architectural state
    logic [63:0]         r_pc, n_pc;
    logic [NUM_REGS-1:0] r_valid;
    logic [63:0]         r_a0, n_a0;
    logic                r_stopped;
    t_status             r_stop_code;

    // execute register
    logic        r_ex_valid;
    logic        r_ex_kind;
    logic [31:0] r_ex_instr;
    logic        r_mul_ph;
    logic [63:0] r_mul_lo;
    logic [31:0] r_mul_x1, r_mul_x2;

    // last register-file write, for operands read in the same cycle
    logic        r_wr_valid;
    logic [4:0]  r_wr_addr;
    logic [63:0] r_wr_data;

    // result register
    logic        r_out_valid;
    logic [63:0] r_out_pc;
    t_status     r_out_status;
    logic [63:0] r_out_a0;

    // handshakes
    logic s_accept, ex_done, mul_first;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign ex_done    = r_ex_valid && !mul_first && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_ex_valid || ex_done;

    // instruction fields
    logic [6:0] op, f7;
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [5:0] f6, sh_imm;
    assign op     = r_ex_instr[6:0];
    assign rd     = r_ex_instr[11:7];
    assign f3     = r_ex_instr[14:12];
    assign rs1    = r_ex_instr[19:15];
    assign rs2    = r_ex_instr[24:20];
    assign f7     = r_ex_instr[31:25];
    assign f6     = r_ex_instr[31:26];
    assign sh_imm = r_ex_instr[25:20];

    // register file: two copies give two read ports
    logic [31:0]   rd_instr;
    logic [AW-1:0] raddr1, raddr2, waddr;
    logic [63:0]   q1, q2;
    logic          wr_en;
    logic [63:0]   wr_data;

    assign rd_instr = s_accept ? i_s_tdata : r_ex_instr;
    assign raddr1   = rd_instr[15+AW-1:15];
    assign raddr2   = rd_instr[20+AW-1:20];
    assign waddr    = rd[AW-1:0];

    rv64se_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (wr_data),
        .i_raddr (raddr1),
        .o_rdata (q1)
    );

    rv64se_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (wr_data),
        .i_raddr (raddr2),
        .o_rdata (q2)
    );

    // value an entry holds since the last restart when never written
    function automatic logic [63:0] f_init(
        input logic [4:0]  idx,
        input logic [63:0] sp,
        input logic [63:0] a0,
        input logic [63:0] a1,
        input logic [63:0] a2,
        input logic [63:0] a3
    );
        logic [63:0] v;
        v = '0;
        if (idx == REG_SP) v = sp;
        if (idx == REG_A0) v = a0;
        if (idx == REG_A1) v = a1;
        if (idx == REG_A2) v = a2;
        if (idx == REG_A3) v = a3;
        return v;
    endfunction

    // operand selection: x0 and out-of-range read zero, then bypass, RAM, restart value
    logic        rs1_ok, rs2_ok, rd_ok;
    logic [63:0] opa, opb;
    assign rs1_ok = (rs1 != 5'd0) && ({27'd0, rs1} < NUM_REGS);
    assign rs2_ok = (rs2 != 5'd0) && ({27'd0, rs2} < NUM_REGS);
    assign rd_ok  = (rd != 5'd0) && ({27'd0, rd} < NUM_REGS);

    assign opa = !rs1_ok ? 64'd0 :
                 (r_wr_valid && r_wr_addr == rs1) ? r_wr_data :
                 r_valid[rs1[AW-1:0]] ? q1 :
                 f_init(rs1, r_init_sp, r_init_a0, r_init_a1, r_init_a2, r_init_a3);
    assign opb = !rs2_ok ? 64'd0 :
                 (r_wr_valid && r_wr_addr == rs2) ? r_wr_data :
                 r_valid[rs2[AW-1:0]] ? q2 :
                 f_init(rs2, r_init_sp, r_init_a0, r_init_a1, r_init_a2, r_init_a3);

    // decode and execute
    logic [63:0] imm, br_off, pc_plus4, res;
    logic        do_wr, set_err, is_mul, taken;
    t_status     status;

    assign imm      = {{52{r_ex_instr[31]}}, r_ex_instr[31:20]};
    assign br_off   = {{51{r_ex_instr[31]}}, r_ex_instr[31], r_ex_instr[7],
                       r_ex_instr[30:25], r_ex_instr[11:8], 1'b0};
    assign pc_plus4 = r_pc + 64'd4;

    always_comb begin
        n_pc    = r_pc;
        status  = ST_RUN;
        do_wr   = 1'b0;
        res     = '0;
        set_err = 1'b0;
        is_mul  = 1'b0;
        taken   = 1'b0;
        if (r_ex_kind == KIND_RESTART) begin
            n_pc   = r_cfg_pc;
            status = (r_cfg_pc == 64'd0) ? ST_HALT : ST_RUN;
        end else if (r_stopped) begin
            status = r_stop_code;
        end else if (r_pc == 64'd0) begin
            status = ST_HALT;
        end else begin
            unique case (op)
                OP_REG: begin
                    do_wr = 1'b1;
                    n_pc  = pc_plus4;
                    unique case ({f7, f3})
                        FN_ADD: res = opa + opb;
                        FN_MUL: begin
                            is_mul = 1'b1;
                            res    = r_mul_lo + {r_mul_x1 + r_mul_x2, 32'd0};
                        end
                        FN_SUB: res = opa - opb;
                        FN_SLL: res = opa << opb[5:0];
                        FN_SRL: res = opa >> opb[5:0];
                        FN_SRA: res = 64'($signed(opa) >>> opb[5:0]);
                        FN_AND: res = opa & opb;
                        default: begin
                            status = ST_BADFN;
                        end
                    endcase
                end
                OP_IMM: begin
                    do_wr = 1'b1;
                    n_pc  = pc_plus4;
                    if (f3 == F3_ADD) begin
                        res = opa + imm;
                    end else if (f3 == F3_SLL && f6 == F6_BASE) begin
                        res = opa << sh_imm;
                    end else if (f3 == F3_SR && f6 == F6_BASE) begin
                        res = opa >> sh_imm;
                    end else if (f3 == F3_SR && f6 == F6_ALT) begin
                        res = 64'($signed(opa) >>> sh_imm);
                    end else begin
                        status = ST_BADFN;
                    end
                end
                OP_JALR: begin
                    do_wr = 1'b1;
                    res   = pc_plus4;
                    n_pc  = (opa + imm) & ~64'd1;
                end
                OP_BRANCH: begin
                    unique case (f3)
                        F3_BEQ: taken = (opa == opb);
                        F3_BNE: taken = (opa != opb);
                        F3_BLT: taken = ($signed(opa) < $signed(opb));
                        F3_BGE: taken = ($signed(opa) >= $signed(opb));
                        default: status = ST_BADFN;
                    endcase
                    n_pc = taken ? r_pc + br_off : pc_plus4;
                end
                default: begin
                    status = ST_BADOP;
                end
            endcase
            // an error changes nothing
            if (status != ST_RUN) begin
                set_err = 1'b1;
                do_wr   = 1'b0;
                n_pc    = r_pc;
            end else if (n_pc == 64'd0) begin
                status = ST_HALT;
            end
        end
    end

    assign mul_first = r_ex_valid && is_mul && !r_mul_ph;
    assign wr_en     = ex_done && do_wr && rd_ok;
    assign wr_data   = res;
    assign n_a0      = (r_ex_kind == KIND_RESTART) ? r_cfg_a0 :
                       (do_wr && rd == REG_A0) ? res : r_a0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pc <= '0;
            r_cfg_sp <= '0;
            r_cfg_a0 <= '0;
            r_cfg_a1 <= '0;
            r_cfg_a2 <= '0;
            r_cfg_a3 <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_START_PC:  r_cfg_pc <= i_cfg_wdata;
                CFG_STACK_TOP: r_cfg_sp <= i_cfg_wdata;
                CFG_ARG_ZERO:  r_cfg_a0 <= i_cfg_wdata;
                CFG_ARG_ONE:   r_cfg_a1 <= i_cfg_wdata;
                CFG_ARG_TWO:   r_cfg_a2 <= i_cfg_wdata;
                CFG_ARG_THREE: r_cfg_a3 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // execute register and MUL partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
            r_mul_ph   <= 1'b0;
        end else begin
            if (s_accept) begin
                r_ex_valid <= 1'b1;
            end else if (ex_done) begin
                r_ex_valid <= 1'b0;
            end
            if (ex_done) begin
                r_mul_ph <= 1'b0;
            end else if (mul_first) begin
                r_mul_ph <= 1'b1;
            end
        end
        if (s_accept) begin
            r_ex_kind  <= i_s_tuser;
            r_ex_instr <= i_s_tdata;
        end
        if (mul_first) begin
            r_mul_lo <= opa[31:0] * opb[31:0];
            r_mul_x1 <= 32'(opa[31:0] * opb[63:32]);
            r_mul_x2 <= 32'(opa[63:32] * opb[31:0]);
        end
    end

    // architectural state and write bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_valid     <= '0;
            r_a0        <= '0;
            r_stopped   <= 1'b0;
            r_stop_code <= ST_RUN;
            r_init_sp   <= '0;
            r_init_a0   <= '0;
            r_init_a1   <= '0;
            r_init_a2   <= '0;
            r_init_a3   <= '0;
            r_wr_valid  <= 1'b0;
        end else begin
            r_wr_valid <= wr_en;
            if (ex_done) begin
                r_pc <= n_pc;
                r_a0 <= n_a0;
                if (r_ex_kind == KIND_RESTART) begin
                    r_valid     <= '0;
                    r_stopped   <= 1'b0;
                    r_stop_code <= ST_RUN;
                    r_init_sp   <= r_cfg_sp;
                    r_init_a0   <= r_cfg_a0;
                    r_init_a1   <= r_cfg_a1;
                    r_init_a2   <= r_cfg_a2;
                    r_init_a3   <= r_cfg_a3;
                end else begin
                    if (wr_en) begin
                        r_valid[waddr] <= 1'b1;
                    end
                    if (set_err) begin
                        r_stopped   <= 1'b1;
                        r_stop_code <= status;
                    end
                end
            end
        end
        r_wr_addr <= rd;
        r_wr_data <= wr_data;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ex_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (ex_done) begin
            r_out_pc     <= n_pc;
            r_out_status <= status;
            r_out_a0     <= n_a0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_a0, r_out_status, r_out_pc};

    // checks
    a_restart_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ex_done && r_ex_kind == KIND_RESTART) |=>
            (r_out_status == ST_RUN || r_out_status == ST_HALT) && !r_stopped)
        else $error("restart produced an error status");

    a_stop_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_stop_code == ST_BADOP || r_stop_code == ST_BADFN))
        else $error("stopped without an error code");

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (rd != 5'd0 && !set_err))
        else $error("register write on x0 or on an erroring instruction");

    a_mul_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_ph |-> (r_ex_valid && is_mul))
        else $error("multiply second phase without a multiply in execute");

    a_error_holds_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ex_done && set_err) |=> (r_pc == $past(r_pc)))
        else $error("pc moved on an erroring instruction");

endmodule

/* tb/sv/rv64_subset_execute_checker.sv */
// Checker for rv64_subset_execute: tracks architectural state, predicts and compares results.
`timescale 1ns / 1ps

module rv64_subset_execute_checker #(
    parameter int NUM_REGS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // item channel, watched only
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [31:0]  i_s_tdata,    // [31:0] instr_word
    input  logic         i_s_tuser,    // [0] kind
    // result channel, watched only
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [135:0] i_m_tdata,    // [63:0] next_pc, [65:64] status, [129:66] a0_value
    // configuration writes, watched only
    input  logic         i_cfg_wr_en,
    input  rv64se_pkg::t_cfg_idx i_cfg_index,
    input  logic [63:0]  i_cfg_wdata,
    // totals for the test top
    output int           o_error_count,
    output int           o_pending,
    output int           o_checked
);
    import rv64se_pkg::*;

    typedef struct packed {
        logic [63:0] next_pc;
        t_status     status;
        logic [63:0] a0;
    } t_retire;

    // Shadow architectural state
    logic [63:0] gpr [NUM_REGS];
    logic [63:0] pc;
    logic        stopped;
    t_status     stop_status;
    logic [63:0] boot_cfg [0:5];

    t_retire due_results [$];
    int      mismatches = 0;
    int      compared   = 0;

    function automatic logic [63:0] read_gpr(logic [4:0] n);
        if (n == 5'd0 || n >= NUM_REGS) return 64'd0;
        return gpr[n];
    endfunction

    function automatic void write_gpr(logic [4:0] n, logic [63:0] v);
        if (n != 5'd0 && n < NUM_REGS) gpr[n] = v;
    endfunction

    // Apply one instruction word; returns ST_RUN or the error it raises
    function automatic t_status run_instr(logic [31:0] w);
        logic [6:0]  opc;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [5:0]  f6;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] imm;
        logic [63:0] boff;
        logic [63:0] res;
        logic [63:0] target;
        logic        taken;
        opc  = w[6:0];
        rd   = w[11:7];
        f3   = w[14:12];
        rs1  = w[19:15];
        rs2  = w[24:20];
        f7   = w[31:25];
        f6   = w[31:26];
        a    = read_gpr(rs1);
        b    = read_gpr(rs2);
        imm  = {{52{w[31]}}, w[31:20]};
        boff = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (opc)
            OP_REG: begin
                case ({f7, f3})
                    FN_ADD: res = a + b;
                    FN_MUL: res = a * b;
                    FN_SUB: res = a - b;
                    FN_SLL: res = a << b[5:0];
                    FN_SRL: res = a >> b[5:0];
                    FN_SRA: res = $signed(a) >>> b[5:0];
                    FN_AND: res = a & b;
                    default: return ST_BADFN;
                endcase
                write_gpr(rd, res);
                pc = pc + 64'd4;
            end
            OP_IMM: begin
                if (f3 == F3_ADD) res = a + imm;
                else if (f3 == F3_SLL && f6 == F6_BASE) res = a << w[25:20];
                else if (f3 == F3_SR && f6 == F6_BASE) res = a >> w[25:20];
                else if (f3 == F3_SR && f6 == F6_ALT) res = $signed(a) >>> w[25:20];
                else return ST_BADFN;
                write_gpr(rd, res);
                pc = pc + 64'd4;
            end
            OP_JALR: begin
                // target uses rs1 as read before the link write
                target = (a + imm) & ~64'd1;
                write_gpr(rd, pc + 64'd4);
                pc = target;
            end
            OP_BRANCH: begin
                case (f3)
                    F3_BEQ: taken = (a == b);
                    F3_BNE: taken = (a != b);
                    F3_BLT: taken = ($signed(a) < $signed(b));
                    F3_BGE: taken = ($signed(a) >= $signed(b));
                    default: return ST_BADFN;
                endcase
                pc = taken ? pc + boff : pc + 64'd4;
            end
            default: return ST_BADOP;
        endcase
        return ST_RUN;
    endfunction

    // Expected result of one accepted item
    function automatic t_retire step_core(logic kind, logic [31:0] w);
        t_retire r;
        t_status st;
        if (kind == KIND_RESTART) begin
            for (int k = 0; k < NUM_REGS; k++) gpr[k] = 64'd0;
            pc = boot_cfg[CFG_START_PC];
            write_gpr(REG_SP, boot_cfg[CFG_STACK_TOP]);
            write_gpr(REG_A0, boot_cfg[CFG_ARG_ZERO]);
            write_gpr(REG_A1, boot_cfg[CFG_ARG_ONE]);
            write_gpr(REG_A2, boot_cfg[CFG_ARG_TWO]);
            write_gpr(REG_A3, boot_cfg[CFG_ARG_THREE]);
            stopped     = 1'b0;
            stop_status = ST_RUN;
            st = (pc == 64'd0) ? ST_HALT : ST_RUN;
        end else if (stopped) begin
            st = stop_status;
        end else if (pc == 64'd0) begin
            st = ST_HALT;
        end else begin
            st = run_instr(w);
            if (st != ST_RUN) begin
                stopped     = 1'b1;
                stop_status = st;
            end else if (pc == 64'd0) begin
                st = ST_HALT;
            end
        end
        r.next_pc = pc;
        r.status  = st;
        r.a0      = read_gpr(REG_A0);
        return r;
    endfunction

    // Track transactions on all channels at each edge
    always @(posedge i_clk) begin
        t_retire want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) gpr[k] = 64'd0;
            for (int k = 0; k < 6; k++) boot_cfg[k] = 64'd0;
            pc          = 64'd0;
            stopped     = 1'b0;
            stop_status = ST_RUN;
            due_results.delete();
        end else begin
            // results leave before this edge's item can produce one
            if (i_m_tvalid && i_m_tready) begin
                if (due_results.size() == 0) begin
                    $error("result transaction with no prediction pending: next_pc %h",
                           i_m_tdata[63:0]);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    compared++;
                    if (i_m_tdata[63:0] !== want.next_pc) begin
                        $error("next_pc: expected %h, actual %h", want.next_pc,
                               i_m_tdata[63:0]);
                        mismatches++;
                    end
                    if (i_m_tdata[65:64] !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status,
                               i_m_tdata[65:64]);
                        mismatches++;
                    end
                    if (i_m_tdata[129:66] !== want.a0) begin
                        $error("a0_value: expected %h, actual %h", want.a0,
                               i_m_tdata[129:66]);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                due_results.push_back(step_core(i_s_tuser, i_s_tdata));
            if (i_cfg_wr_en && i_cfg_index <= CFG_ARG_THREE)
                boot_cfg[i_cfg_index] = i_cfg_wdata;
        end
        o_error_count <= mismatches;
        o_pending     <= due_results.size();
        o_checked     <= compared;
    end

endmodule

/* tb/sv/rv64_subset_execute_test.sv */
// Test top for rv64_subset_execute: clock, reset, stimulus, config phases and verdict.
`timescale 1ns / 1ps

module rv64_subset_execute_test;
    import rv64se_pkg::*;

    localparam int         NUM_REGS = 32;
    localparam logic [4:0] R_ZERO   = 5'd0;
    localparam logic [4:0] R_RA     = 5'd1;

    logic         i_clk;
    logic         i_rst_n     = 1'b0;
    logic         i_s_tvalid  = 1'b0;
    logic         o_s_tready;
    logic [31:0]  i_s_tdata   = 32'd0;   // [31:0] instr_word
    logic         i_s_tuser   = 1'b0;    // [0] kind
    logic         o_m_tvalid;
    logic         i_m_tready  = 1'b0;
    logic [135:0] o_m_tdata;             // [63:0] next_pc, [65:64] status, [129:66] a0_value
    logic         i_cfg_wr_en = 1'b0;
    t_cfg_idx     i_cfg_index = CFG_START_PC;
    logic [63:0]  i_cfg_wdata = 64'd0;

    int error_count;
    int pending;
    int checked;

    bit calm_run     = 1'b0;   // no idling on either side while set
    int holds_asked  = 0;
    int holds_done   = 0;
    int items_sent   = 0;
    int restarts     = 0;
    int cfg_writes   = 0;

    rv64_subset_execute #(.NUM_REGS(NUM_REGS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    rv64_subset_execute_checker #(.NUM_REGS(NUM_REGS)) u_retire_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_error_count (error_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #1_000_000;
        $display("rv64_subset_execute_test: done, errors");
        $finish;
    end

    // Result side: random back-pressure, plus long hold-offs on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (holds_done < holds_asked) begin
                i_m_tready <= 1'b0;
                repeat (150) @(posedge i_clk);
                holds_done++;
            end else if (calm_run) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 24);
            end
        end
    end

    // Instruction encoders
    function automatic logic [31:0] enc_r(logic [9:0] fn, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [4:0] rd);
        return {fn[9:3], rs2, rs1, fn[2:0], rd, OP_REG};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] off, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OP_BRANCH};
    endfunction

    // Register choice biased toward the ones a restart loads
    function automatic logic [4:0] pick_reg();
        case ($urandom_range(7))
            0:       return R_ZERO;
            1:       return REG_SP;
            2:       return REG_A0;
            3:       return REG_A1;
            4:       return REG_A2;
            5:       return REG_A3;
            default: return 5'($urandom_range(31));
        endcase
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(5))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            4:       return 64'($urandom_range(255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly legal instructions with random operands; some malformed, some noise
    function automatic logic [31:0] next_word();
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [11:0] imm;
        int          pick;
        rd   = ($urandom_range(2) == 0) ? REG_A0 : pick_reg();
        rs1  = pick_reg();
        rs2  = pick_reg();
        imm  = 12'($urandom);
        pick = $urandom_range(99);
        if (pick < 4) return $urandom;
        if (pick < 8) begin
            case ($urandom_range(2))
                0: return enc_r(10'($urandom), rs2, rs1, rd);
                1: return enc_i({6'($urandom), 6'($urandom)}, rs1,
                                ($urandom_range(1) == 0) ? F3_SLL : F3_SR, rd, OP_IMM);
                default: return enc_b({12'($urandom_range(4095)), 1'b0}, rs2, rs1,
                                      {1'($urandom), 1'b1, 1'($urandom)});
            endcase
        end
        case ($urandom_range(15))
            0:  return enc_r(FN_ADD, rs2, rs1, rd);
            1:  return enc_r(FN_SUB, rs2, rs1, rd);
            2:  return enc_r(FN_MUL, rs2, rs1, rd);
            3:  return enc_r(FN_SLL, rs2, rs1, rd);
            4:  return enc_r(FN_SRL, rs2, rs1, rd);
            5:  return enc_r(FN_SRA, rs2, rs1, rd);
            6:  return enc_r(FN_AND, rs2, rs1, rd);
            7:  return enc_i(imm, rs1, F3_ADD, rd, OP_IMM);
            8:  return enc_i({F6_BASE, imm[5:0]}, rs1, F3_SLL, rd, OP_IMM);
            9:  return enc_i({F6_BASE, imm[5:0]}, rs1, F3_SR, rd, OP_IMM);
            10: return enc_i({F6_ALT, imm[5:0]}, rs1, F3_SR, rd, OP_IMM);
            11: begin
                // x0 base with zero offset jumps to pc 0 and halts
                if (rs1 == R_ZERO && $urandom_range(1) == 0) imm = 12'd0;
                return enc_i(imm, rs1, 3'($urandom), rd, OP_JALR);
            end
            12: return enc_b({12'($urandom_range(4095)), 1'b0}, rs2, rs1, F3_BEQ);
            13: return enc_b({12'($urandom_range(4095)), 1'b0}, rs2, rs1, F3_BNE);
            14: return enc_b({12'($urandom_range(4095)), 1'b0}, rs2, rs1, F3_BLT);
            default: return enc_b({12'($urandom_range(4095)), 1'b0}, rs2, rs1, F3_BGE);
        endcase
    endfunction

    // One item transaction, with random idle cycles ahead of it
    task automatic send(logic kind, logic [31:0] w);
        while (!calm_run && $urandom_range(99) < 24) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= w;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        if (kind == KIND_RESTART) restarts++;
    endtask

    // Drain: stop offering and wait until every prediction is matched
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [63:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic load_boot(logic [63:0] start, logic [63:0] sp, logic [63:0] a0,
                             logic [63:0] a1, logic [63:0] a2, logic [63:0] a3);
        write_cfg(CFG_START_PC, start);
        write_cfg(CFG_STACK_TOP, sp);
        write_cfg(CFG_ARG_ZERO, a0);
        write_cfg(CFG_ARG_ONE, a1);
        write_cfg(CFG_ARG_TWO, a2);
        write_cfg(CFG_ARG_THREE, a3);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stimulus and verdict
    initial begin
        logic [63:0] start;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Restart with start_pc still zero: halted, execute is ignored
        send(KIND_RESTART, 32'd0);
        send(KIND_EXEC, enc_r(FN_ADD, REG_A2, REG_A0, REG_A0));
        settle();
        load_boot(64'h8000_0000_0000_0000, '1, '1, 64'h8000_0000_0000_0001, 64'd3, 64'd70);
        send(KIND_RESTART, 32'hFFFF_FFFF);
        // every operation; shift amounts above 63 through a3
        send(KIND_EXEC, enc_r(FN_ADD, REG_A2, REG_A0, REG_A0));
        send(KIND_EXEC, enc_r(FN_SUB, REG_A1, R_ZERO, REG_A0));
        send(KIND_EXEC, enc_r(FN_MUL, REG_SP, REG_A1, REG_A0));
        send(KIND_EXEC, enc_r(FN_SLL, REG_A3, REG_A2, REG_A0));
        send(KIND_EXEC, enc_r(FN_SRL, REG_A3, REG_A1, REG_A0));
        send(KIND_EXEC, enc_r(FN_SRA, REG_A3, REG_A1, REG_A0));
        send(KIND_EXEC, enc_r(FN_AND, REG_A1, REG_SP, REG_A0));
        send(KIND_EXEC, enc_i(12'h800, REG_A0, F3_ADD, REG_A0, OP_IMM));
        send(KIND_EXEC, enc_i(12'd5, REG_SP, F3_ADD, R_ZERO, OP_IMM));
        send(KIND_EXEC, enc_i({F6_BASE, 6'd63}, REG_A1, F3_SLL, REG_A0, OP_IMM));
        send(KIND_EXEC, enc_i({F6_BASE, 6'd63}, REG_SP, F3_SR, REG_A0, OP_IMM));
        send(KIND_EXEC, enc_i({F6_ALT, 6'd1}, REG_A1, F3_SR, REG_A0, OP_IMM));
        send(KIND_EXEC, enc_b(13'h1FF8, REG_A2, REG_A2, F3_BEQ));
        send(KIND_EXEC, enc_b(13'd16, REG_A2, REG_A2, F3_BNE));
        send(KIND_EXEC, enc_b(13'h0FFE, REG_A2, REG_A1, F3_BLT));
        send(KIND_EXEC, enc_b(13'h1000, REG_A2, REG_A1, F3_BGE));
        // link register equals base register; funct3 is don't-care
        send(KIND_EXEC, enc_i(12'd1, REG_A0, F3_AND, REG_A0, OP_JALR));
        // SLLI with the arithmetic funct6 is illegal; the block then stops
        send(KIND_EXEC, enc_i({F6_ALT, 6'd3}, REG_A0, F3_SLL, REG_A0, OP_IMM));
        send(KIND_EXEC, enc_r(FN_ADD, REG_A2, REG_A0, REG_A0));
        send(KIND_RESTART, 32'd0);
        send(KIND_EXEC, 32'hFFFF_FFFF);
        send(KIND_RESTART, 32'd0);
        send(KIND_EXEC, enc_i(12'd0, R_ZERO, F3_ADD, R_RA, OP_JALR));

        // Random phases, each under a fresh boot setup
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            calm_run = 1'b0;
            if (ph == 0) begin
                load_boot('1, '1, '1, '1, '1, '1);
            end else if (ph == 1) begin
                load_boot(64'd4, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
            end else begin
                start = pick_value();
                if (start == 64'd0) start = 64'h100;
                load_boot(start, pick_value(), pick_value(), pick_value(), pick_value(),
                          pick_value());
            end
            if (ph == 2) calm_run = 1'b1;
            if (ph == 4) holds_asked++;
            send(KIND_RESTART, $urandom);
            repeat (209) begin
                if ($urandom_range(99) < 5) send(KIND_RESTART, $urandom);
                else send(KIND_EXEC, next_word());
            end
        end

        settle();
        repeat (6) @(posedge i_clk);
        $display("summary: %0d items sent (%0d restarts), %0d results compared, %0d config writes",
                 items_sent, restarts, checked, cfg_writes);
        if (error_count == 0) begin
            $display("rv64_subset_execute_test: done, clean");
        end else begin
            $display("rv64_subset_execute_test: done, errors");
        end
        $finish;
    end

endmodule
